### rtl/vector3_normalize_core_assert.svh
// Assertion macros used by the checker file.
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define VN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/vn_pkg.sv
package vn_pkg;

  localparam int unsigned CompW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned SumW = 64;
  localparam int unsigned ThrW = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd1;
  // Square root gives one result bit per stage.
  localparam int unsigned SqrtStages = 32;
  // Quotient magnitude is at most 2^16, so the quotient needs 17 bits, one per divider stage.
  localparam int unsigned QuotW = 17;
  localparam int unsigned DivStages = QuotW;

  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic [CompW-1:0]        vec_length;
    logic                    was_zero;
  } vn_out_t;

endpackage

### rtl/vector3_normalize_core.sv
// Pipeline order: stage A, stage B, the square-root stages, stage C, the divider stages, output register.
// Throughput: one request per cycle unless stalled; the square root and the divider are
// pipelined with one bit per stage, so every stage takes a new request each cycle.
// A stall freezes the whole pipeline; the output register holds its result.
// Reset clears every valid bit and sets the threshold register thr_q to 1.
module vector3_normalize_core #(
  parameter int unsigned ThrWidth = vn_pkg::ThrW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ThrWidth-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vn_pkg::vn_in_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vn_pkg::vn_out_t     out_data_o
);

  localparam int unsigned CW = vn_pkg::CompW;
  localparam int unsigned SW = vn_pkg::SumW;
  localparam int unsigned NS = vn_pkg::SqrtStages;
  localparam int unsigned QW = vn_pkg::QuotW;
  localparam int unsigned ND = vn_pkg::DivStages;
  localparam int unsigned NW = CW + vn_pkg::FracW;  // dividend width

  logic                advance;
  logic [ThrWidth-1:0] thr_q;

  assign advance = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrWidth'(vn_pkg::ThrReset);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Stage A: magnitudes and squares.
  logic              a_v_q;
  vn_pkg::vn_in_t    a_in_q;
  logic [2*CW-1:0]   a_sq_q [3];
  logic [CW-1:0]     mag [3];

  always_comb begin
    mag[0] = in_data_i.comp_x[CW-1] ? CW'(-in_data_i.comp_x) : in_data_i.comp_x;
    mag[1] = in_data_i.comp_y[CW-1] ? CW'(-in_data_i.comp_y) : in_data_i.comp_y;
    mag[2] = in_data_i.comp_z[CW-1] ? CW'(-in_data_i.comp_z) : in_data_i.comp_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (advance) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_in_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        a_sq_q[i] <= mag[i] * mag[i];
      end
    end
  end

  // Stage B: sum of squares (fits in 64 bits).
  logic           b_v_q;
  vn_pkg::vn_in_t b_in_q;
  logic [SW-1:0]  b_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (advance) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_in_q  <= a_in_q;
      b_sum_q <= a_sq_q[0] + a_sq_q[1] + a_sq_q[2];
    end
  end

  // Square root pipeline: restoring method, one root bit per stage.
  logic           s_v_q   [NS+1];
  vn_pkg::vn_in_t s_in_q  [NS+1];
  logic [SW-1:0]  s_rad_q [NS+1];  // remaining radicand bits, shifted left
  logic [CW+1:0]  s_rem_q [NS+1];
  logic [CW-1:0]  s_root_q[NS+1];

  assign s_v_q[0]    = b_v_q;
  assign s_in_q[0]   = b_in_q;
  assign s_rad_q[0]  = b_sum_q;
  assign s_rem_q[0]  = '0;
  assign s_root_q[0] = '0;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    logic [CW+1:0] rem_sh;
    logic [CW+1:0] trial;
    logic          take;
    assign rem_sh = {s_rem_q[g][CW-1:0], s_rad_q[g][SW-1 -: 2]};
    assign trial  = {s_root_q[g], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[g+1] <= 1'b0;
      end else if (advance) begin
        s_v_q[g+1] <= s_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        s_in_q[g+1]   <= s_in_q[g];
        s_rad_q[g+1]  <= {s_rad_q[g][SW-3:0], 2'b00};
        s_rem_q[g+1]  <= take ? rem_sh - trial : rem_sh;
        s_root_q[g+1] <= {s_root_q[g][CW-2:0], take};
      end
    end
  end

  // Stage C: threshold compare and dividend setup.
  logic           c_v_q;
  vn_pkg::vn_in_t c_in_q;
  logic [CW-1:0]  c_len_q;
  logic           c_zero_q;
  logic [NW-1:0]  c_num_q [3];
  logic [2:0]     c_neg_q;
  logic [CW-1:0]  smag [3];
  logic [CW-1:0]  len_s;

  assign len_s = s_root_q[NS];
  always_comb begin
    smag[0] = s_in_q[NS].comp_x[CW-1] ? CW'(-s_in_q[NS].comp_x) : s_in_q[NS].comp_x;
    smag[1] = s_in_q[NS].comp_y[CW-1] ? CW'(-s_in_q[NS].comp_y) : s_in_q[NS].comp_y;
    smag[2] = s_in_q[NS].comp_z[CW-1] ? CW'(-s_in_q[NS].comp_z) : s_in_q[NS].comp_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (advance) begin
      c_v_q <= s_v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_in_q   <= s_in_q[NS];
      c_len_q  <= len_s;
      c_zero_q <= len_s <= CW'(thr_q);
      c_neg_q  <= {s_in_q[NS].comp_z[CW-1], s_in_q[NS].comp_y[CW-1],
                   s_in_q[NS].comp_x[CW-1]};
      for (int i = 0; i < 3; i++) begin
        c_num_q[i] <= {smag[i], {vn_pkg::FracW{1'b0}}};
      end
    end
  end

  // Divider pipeline: three lanes of restoring division, one quotient bit per
  // stage. The quotient never exceeds 2^16, so only its low QW bits are built.
  logic           d_v_q   [ND+1];
  vn_pkg::vn_in_t d_in_q  [ND+1];
  logic [CW-1:0]  d_len_q [ND+1];
  logic           d_zero_q[ND+1];
  logic [2:0]     d_neg_q [ND+1];
  logic [NW-1:0]  d_num_q [ND+1][3];
  logic [CW:0]    d_rem_q [ND+1][3];
  logic [QW-1:0]  d_quo_q [ND+1][3];

  assign d_v_q[0]    = c_v_q;
  assign d_in_q[0]   = c_in_q;
  assign d_len_q[0]  = c_len_q;
  assign d_zero_q[0] = c_zero_q;
  assign d_neg_q[0]  = c_neg_q;
  for (genvar l = 0; l < 3; l++) begin : g_lane0
    // Top NW-QW dividend bits are below the divisor, so they preload the remainder.
    assign d_num_q[0][l] = {c_num_q[l][QW-1:0], {(NW-QW){1'b0}}};
    assign d_rem_q[0][l] = (CW+1)'(c_num_q[l][NW-1:QW]);
    assign d_quo_q[0][l] = '0;
  end

  for (genvar g = 0; g < ND; g++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[g+1] <= 1'b0;
      end else if (advance) begin
        d_v_q[g+1] <= d_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        d_in_q[g+1]   <= d_in_q[g];
        d_len_q[g+1]  <= d_len_q[g];
        d_zero_q[g+1] <= d_zero_q[g];
        d_neg_q[g+1]  <= d_neg_q[g];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW:0] rsh;
      logic        ge;
      assign rsh = {d_rem_q[g][l][CW-1:0], d_num_q[g][l][NW-1]};
      assign ge  = rsh >= {1'b0, d_len_q[g]};
      always_ff @(posedge clk_i) begin
        if (advance) begin
          d_num_q[g+1][l] <= {d_num_q[g][l][NW-2:0], 1'b0};
          d_rem_q[g+1][l] <= ge ? rsh - {1'b0, d_len_q[g]} : rsh;
          d_quo_q[g+1][l] <= {d_quo_q[g][l][QW-2:0], ge};
        end
      end
    end
  end

  // Output register: sign and pass-through select.
  logic [CW-1:0] uq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq[i] = d_neg_q[ND][i] ? CW'(-CW'(d_quo_q[ND][i])) : CW'(d_quo_q[ND][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= d_v_q[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_o.unit_x     <= d_zero_q[ND] ? d_in_q[ND].comp_x : uq[0];
      out_data_o.unit_y     <= d_zero_q[ND] ? d_in_q[ND].comp_y : uq[1];
      out_data_o.unit_z     <= d_zero_q[ND] ? d_in_q[ND].comp_z : uq[2];
      out_data_o.vec_length <= d_len_q[ND];
      out_data_o.was_zero   <= d_zero_q[ND];
    end
  end

endmodule

### rtl/vn_checker.sv
`include "vector3_normalize_core_assert.svh"
// Port-level checks for the normalize core.
module vn_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input vn_pkg::vn_out_t out_data_o
);
  // A stalled result stays put.
  `VN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  // Input side is not ready while the output is stalled.
  `VN_ASSERT_IMPL(a_ready, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  // A result not flagged as zero always reports a nonzero length.
  `VN_ASSERT_IMPL(a_len, clk_i, rst_ni, out_valid_o && !out_data_o.was_zero,
                  out_data_o.vec_length > 32'd0)
endmodule

bind vector3_normalize_core vn_checker u_vn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
